// File: rtl/core/mt16_pkg.sv
// Shared constants and types for the 16-bit Mersenne Twister generator.
`default_nettype none
package mt16_pkg;

	localparam int WORD_W          = 16;
	localparam int STATE_WORDS_DEF = 312;
	localparam int TWIST_OFFSET    = 197;

	localparam logic [WORD_W-1:0] TWIST_CONST  = 16'h98BF;
	localparam logic [8:0]        SEED_MULT    = 9'd269;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 16'd2176;
	localparam logic [WORD_W-1:0] TEMPER_B     = 16'h9D60;
	localparam logic [WORD_W-1:0] TEMPER_C     = 16'hEC00;
	localparam logic [WORD_W-1:0] HIGH_MASK    = 16'h8000;
	localparam logic [WORD_W-1:0] LOW_MASK     = 16'h7FFF;

	typedef enum logic {
		CMD_SEED = 1'b0,
		CMD_DRAW = 1'b1
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/mt16_if.sv
// Request and response channel interfaces for the generator.
`default_nettype none
interface mt16_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] seed;

	modport source (output valid, output cmd, output seed, input ready);
	modport sink   (input valid, input cmd, input seed, output ready);
endinterface

interface mt16_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mersenne_twister_16bit.sv
// Top level of the 16-bit Mersenne Twister: sequencer, seeding and twist datapath.
// A seed request (cmd 0) writes all STATE_WORDS store words, one word per cycle,
// using a single 16x9 multiplier; it gives no response. A draw request (cmd 1)
// normally goes from acceptance to a store read and then to tempering into the
// output register, which the draw waits for while it still holds an unclaimed word.
// When the store is used up, the draw first twists it, one word at a time through
// the shared mix unit and the two read ports of the store. A draw with no seed
// ever given first seeds with 2176. The block takes one request at a time and is
// not ready while one is in work; the response waits in its own register, so a new
// request can be accepted while the last word is still unclaimed. There is no
// clearing pass: the store is always seeded before any read.
`default_nettype none
module mersenne_twister_16bit #(
	parameter int STATE_WORDS = mt16_pkg::STATE_WORDS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mt16_req_if.sink   req,
	mt16_rsp_if.source rsp
);
	import mt16_pkg::*;

	localparam int IDX_W = $clog2(STATE_WORDS);
	localparam int POS_W = $clog2(STATE_WORDS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
	localparam logic [POS_W-1:0] POS_FULL = POS_W'(STATE_WORDS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_TW_PRE,
		S_TW_CUR,
		S_TW_RD,
		S_TW_WR,
		S_DR_RD,
		S_DR_OUT
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;      // word index for fill and twist
	logic [POS_W-1:0]  pos_q;      // next word to draw; full means twist due
	logic              seeded_q;
	logic              pend_q;     // a draw waits behind the default-seed fill
	logic [WORD_W-1:0] x_q;        // running seed product
	logic [WORD_W-1:0] cur_q;      // current word of the twist
	logic [WORD_W-1:0] out_q;
	logic              out_vld_q;

	// store ports
	logic              we;
	logic [IDX_W-1:0]  wa, ra_a, ra_b;
	logic [WORD_W-1:0] wd, rd_a, rd_b;

	logic [IDX_W-1:0]  nxt_idx, far_idx;
	logic [IDX_W:0]    far_sum;
	logic [WORD_W-1:0] mixed, twist_val, tempered;
	logic [24:0]       prod;
	logic              accept;
	logic              out_free;
	logic              out_load;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.random_word = out_q;
	assign out_free = !out_vld_q || rsp.ready;
	assign out_load = (state_q == S_DR_OUT) && out_free;

	// Neighbor and far index of the word being twisted, both wrapping at the end.
	always_comb begin
		nxt_idx = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
		far_sum = (IDX_W+1)'(idx_q) + (IDX_W+1)'(TWIST_OFFSET);
		if (far_sum >= (IDX_W+1)'(STATE_WORDS)) begin
			far_sum = far_sum - (IDX_W+1)'(STATE_WORDS);
		end
		far_idx = far_sum[IDX_W-1:0];
	end

	// Twist mix: rd_a holds the successor word, rd_b the far word.
	always_comb begin
		mixed     = (cur_q & HIGH_MASK) | (rd_a & LOW_MASK);
		twist_val = rd_b ^ (mixed >> 1);
		if (rd_a[0]) begin
			twist_val = twist_val ^ TWIST_CONST;
		end
	end

	assign prod = 25'(x_q) * 25'(SEED_MULT);

	// Store port steering per sequencer state.
	always_comb begin
		we   = 1'b0;
		wa   = idx_q;
		wd   = twist_val;
		ra_a = pos_q[IDX_W-1:0];
		ra_b = far_idx;
		case (state_q)
			S_FILL: begin
				we = 1'b1;
				wd = x_q;
			end
			S_TW_PRE: begin
				ra_a = '0;
			end
			S_TW_CUR, S_TW_RD: begin
				ra_a = nxt_idx;
			end
			S_TW_WR: begin
				we = 1'b1;
			end
			default: begin
				ra_a = pos_q[IDX_W-1:0];
			end
		endcase
	end

	mt16_ram #(
		.DEPTH(STATE_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.wa   (wa),
		.wd   (wd),
		.ra_a (ra_a),
		.ra_b (ra_b),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	mt16_temper u_temper (
		.word_in  (rd_a),
		.word_out (tempered)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			pos_q     <= POS_FULL;
			seeded_q  <= 1'b0;
			pend_q    <= 1'b0;
			x_q       <= '0;
			cur_q     <= '0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// load a new word, or drop the old one once it is taken
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (req.cmd == CMD_SEED) begin
							// reseed: word 0 is the seed with its low bit set
							x_q     <= req.seed | WORD_W'(1);
							pend_q  <= 1'b0;
							state_q <= S_FILL;
						end else if (pos_q >= POS_FULL) begin
							if (!seeded_q) begin
								// never seeded: fill with the default seed first
								x_q     <= DEFAULT_SEED | WORD_W'(1);
								pend_q  <= 1'b1;
								state_q <= S_FILL;
							end else begin
								state_q <= S_TW_PRE;
							end
						end else begin
							state_q <= S_DR_RD;
						end
					end
				end
				S_FILL: begin
					// write one word, advance the product
					x_q <= prod[WORD_W-1:0];
					if (idx_q == LAST_IDX) begin
						idx_q    <= '0;
						seeded_q <= 1'b1;
						pos_q    <= POS_FULL;
						pend_q   <= 1'b0;
						state_q  <= pend_q ? S_TW_PRE : S_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_TW_PRE: begin
					state_q <= S_TW_CUR;
				end
				S_TW_CUR: begin
					// capture word 0, reads for word 0 already issued
					cur_q   <= rd_a;
					state_q <= S_TW_WR;
				end
				S_TW_RD: begin
					state_q <= S_TW_WR;
				end
				S_TW_WR: begin
					// successor becomes the next current word
					cur_q <= rd_a;
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						pos_q   <= '0;
						state_q <= S_DR_RD;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_TW_RD;
					end
				end
				S_DR_RD: begin
					state_q <= S_DR_OUT;
				end
				S_DR_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						out_q   <= tempered;
						pos_q   <= pos_q + POS_W'(1);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/mt16_ram.sv
// State word store: one write port, two registered read ports.
`default_nettype none
module mt16_ram #(
	parameter int DEPTH = mt16_pkg::STATE_WORDS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   wa,
	input  wire logic [mt16_pkg::WORD_W-1:0] wd,
	input  wire logic [$clog2(DEPTH)-1:0]   ra_a,
	input  wire logic [$clog2(DEPTH)-1:0]   ra_b,
	output logic      [mt16_pkg::WORD_W-1:0] rd_a,
	output logic      [mt16_pkg::WORD_W-1:0] rd_b
);
	import mt16_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a <= mem[ra_a];
		rd_b <= mem[ra_b];
	end

endmodule
`default_nettype wire

// File: rtl/core/mt16_temper.sv
// Output tempering of one 16-bit state word.
`default_nettype none
module mt16_temper (
	input  wire logic [mt16_pkg::WORD_W-1:0] word_in,
	output logic      [mt16_pkg::WORD_W-1:0] word_out
);
	import mt16_pkg::*;

	logic [WORD_W-1:0] y1, y2, y3;

	always_comb begin
		y1       = word_in ^ (word_in >> 6);
		y2       = y1 ^ ((y1 << 3) & TEMPER_B);
		y3       = y2 ^ ((y2 << 7) & TEMPER_C);
		word_out = y3 ^ (y3 >> 9);
	end

endmodule
`default_nettype wire

// File: rtl/core/mt16_chk.sv
// Port-level checker for the generator and its bind to the top level.
`default_nettype none
module mt16_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        req_cmd,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [15:0] rsp_random_word
);
	import mt16_pkg::*;

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_random_word))
		else $error("response word changed while stalled");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("response valid during reset");

	a_seed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_cmd == CMD_SEED) && !rsp_valid |=> !rsp_valid)
		else $error("seed request produced a response");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("ready right after an accepted request");

endmodule

bind mersenne_twister_16bit mt16_chk u_mt16_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_cmd         (req.cmd),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_random_word (rsp.random_word)
);
`default_nettype wire
